>>> src/tbcl_pkg.sv
package tbcl_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam int KEY_W   = 104;
   localparam int INDEX_W = 10;
   localparam int SHL     = 7;
   localparam int SHR     = 14;

   // One request beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] hash;
      logic [63:0] key_addr;
      logic [31:0] key_port;
      logic [7:0]  key_proto;
      logic [63:0] now;
      logic [9:0]  index;
      logic [63:0] peer_addr;
      logic [31:0] peer_port;
      logic [7:0]  peer_proto;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic       found;
      logic       client_side;
      logic [9:0] match_index;
      logic       free_valid;
      logic [9:0] free_index;
      logic       stale_valid;
      logic [9:0] stale_index;
   } rsp_type;

   // One stored entry: client key, server key, last-seen time.
   typedef struct packed {
      logic [KEY_W-1:0] client_key;
      logic [KEY_W-1:0] server_key;
      logic [63:0]      last_seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> src/tbcl_req_if.sv
interface tbcl_req_if;
   import tbcl_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/tbcl_rsp_if.sv
interface tbcl_rsp_if;
   import tbcl_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/tbcl_ram.sv
module tbcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> src/tbcl_front.sv
module tbcl_front #(
   parameter int DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   tbcl_req_if.sink req,
   output logic                  q_valid,
   input  logic                  q_pop,
   output tbcl_pkg::req_type     q_head
);
   import tbcl_pkg::*;

   localparam int PW = $clog2(DEPTH);

   req_type         buf_ff [DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            push;
   req_type         norm;

   // Fold unknown kinds to a no-op delete-free form; index already in range.
   always_comb begin
      norm = req.payload;
      if (req.payload.kind != KIND_LOOKUP && req.payload.kind != KIND_WRITE &&
          req.payload.kind != KIND_DELETE) begin
         norm.kind = KIND_NONE;
      end
   end

   assign req.ready = (cnt_ff != (PW+1)'(DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_head    = buf_ff[rp_ff];

   // Queue pointers and fill count.
   always_comb begin
      wp_in  = push ? PW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = q_pop ? PW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= norm;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(DEPTH)) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
endmodule

>>> src/tbcl_back.sv
module tbcl_back #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int WAYS          = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic [63:0]           max_age,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  tbcl_pkg::req_type     q_head,
   tbcl_rsp_if.source rsp,
   output logic                  busy
);
   import tbcl_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NPROBE = 2 * WAYS;
   localparam int PCW = $clog2(NPROBE + 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW:0]      clr_ff, clr_in;
   req_type          cur_ff, cur_in;
   logic [PCW-1:0]   iss_ff, iss_in;     // probes issued
   logic [PCW-1:0]   chk_ff, chk_in;     // probes checked
   logic             pend_ff, pend_in;   // read data due this cycle
   logic [AW-1:0]    pidx_ff, pidx_in;   // index of pending read
   rsp_type          res_ff, res_in;
   logic             done_ff, done_in;
   rsp_type          out_ff, out_in;
   logic             ovld_ff, ovld_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   logic [31:0]      h2;
   logic [AW-1:0]    b1, b2, probe_addr;
   logic [WW-1:0]    way;
   logic [KEY_W-1:0] key;
   logic             cli_hit, srv_hit, empty, stale;
   logic [63:0]      age_sum;

   tbcl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Bucket starts and the probe address for the next issue.
   always_comb begin
      h2  = (cur_ff.hash << SHL) + (cur_ff.hash >> SHR);
      b1  = AW'(cur_ff.hash) & ~AW'(WAYS - 1);
      b2  = AW'(h2) & ~AW'(WAYS - 1);
      way = WW'(iss_ff >> 1);
      probe_addr = (iss_ff[0] ? b2 : b1) | AW'(way);
   end

   // Compare of the entry read last cycle.
   always_comb begin
      key     = {cur_ff.key_addr, cur_ff.key_port, cur_ff.key_proto};
      cli_hit = (rd_data.client_key == key);
      srv_hit = (rd_data.server_key == key);
      empty   = (rd_data.client_key[KEY_W-1 -: 64] == 64'd0);
      age_sum = max_age + rd_data.last_seen;
      stale   = (age_sum < cur_ff.now);
   end

   assign busy     = (state_ff != ST_IDLE) || ovld_ff;
   assign rsp.valid   = ovld_ff;
   assign rsp.payload = out_ff;

   // Sequencer: clear sweep, then one request at a time.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cur_in   = cur_ff;
      iss_in   = iss_ff;
      chk_in   = chk_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      res_in   = res_ff;
      done_in  = done_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff && !rsp.ready;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = AW'(clr_ff);
      wr_data  = '0;
      rd_addr  = probe_addr;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cur_in  = q_head;
               wr_addr = AW'(q_head.index);
               case (q_head.kind)
                  KIND_WRITE: begin
                     wr_en   = 1'b1;
                     wr_data = '{client_key: {q_head.key_addr, q_head.key_port,
                                              q_head.key_proto},
                                 server_key: {q_head.peer_addr, q_head.peer_port,
                                              q_head.peer_proto},
                                 last_seen: q_head.now};
                     state_in = ST_OUT;
                  end
                  KIND_DELETE: begin
                     // Read-modify-write: fetch entry first.
                     rd_addr  = AW'(q_head.index);
                     pend_in  = 1'b1;
                     state_in = ST_PROBE;
                  end
                  KIND_LOOKUP: begin
                     iss_in   = '0;
                     chk_in   = '0;
                     done_in  = 1'b0;
                     state_in = ST_PROBE;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
               res_in = '0;
            end
         end
         ST_PROBE: begin
            if (cur_ff.kind == KIND_DELETE) begin
               if (pend_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pidx_ff;
                  wr_data  = rd_data;
                  wr_data.client_key[KEY_W-1 -: 64] = 64'd0;
                  state_in = ST_OUT;
               end else begin
                  // Unreachable; the read was issued on entry.
                  state_in = ST_OUT;
               end
            end else begin
               // Issue one read per cycle.
               if (iss_ff != PCW'(NPROBE) && !done_ff) begin
                  pend_in = 1'b1;
                  pidx_in = probe_addr;
                  iss_in  = iss_ff + 1'b1;
               end
               // Check the entry that came back.
               if (pend_ff && !done_ff) begin
                  chk_in = chk_ff + 1'b1;
                  if (cli_hit || srv_hit) begin
                     done_in = 1'b1;
                     res_in  = '0;
                     res_in.found       = 1'b1;
                     res_in.client_side = cli_hit;
                     res_in.match_index = INDEX_W'(pidx_ff);
                  end else if (empty) begin
                     if (!res_ff.free_valid) begin
                        res_in.free_valid = 1'b1;
                        res_in.free_index = INDEX_W'(pidx_ff);
                     end
                  end else if (stale && !res_ff.stale_valid) begin
                     res_in.stale_valid = 1'b1;
                     res_in.stale_index = INDEX_W'(pidx_ff);
                  end
                  if (chk_ff == PCW'(NPROBE - 1)) begin
                     done_in = 1'b1;
                  end
               end
               if (done_ff) begin
                  pend_in  = 1'b0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!ovld_ff || rsp.ready) begin
               out_in   = res_ff;
               ovld_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_IDLE && q_valid && q_head.kind == KIND_DELETE) begin
         pidx_in = AW'(q_head.index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ovld_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         iss_ff   <= '0;
         chk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ovld_ff  <= ovld_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         iss_ff   <= iss_in;
         chk_ff   <= chk_in;
      end
      cur_ff  <= cur_in;
      pidx_ff <= pidx_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.found |-> !rsp.payload.free_valid &&
      !rsp.payload.stale_valid) else $error("hit with miss info");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
   a_chk_bound: assert property (@(posedge clock) disable iff (reset)
      chk_ff <= PCW'(NPROBE)) else $error("too many probes");
endmodule

>>> src/two_bucket_connection_lookup.sv
// Connection table lookup with two candidate buckets per hash.
// Request channel (req_*): one beat carries a lookup, an entry write or an
// entry delete. Response channel (rsp_*): exactly one beat per request, in
// order. Config channel (csr_*): writes the 64-bit maximum age; the user
// must write it only while the block is idle; the block does not enforce it.
// A lookup reads one entry per cycle from a table memory with one read port,
// way i of bucket one then way i of bucket two, stopping at the first hit.
// A delete is a read-modify-write of the entry through that read port.
// A two-beat queue in front accepts requests while the back end works
// and while a finished response waits in the output register.
// After reset the table is swept to zero, one entry a cycle, through all
// TABLE_ENTRIES entries; requests queue meanwhile but are not started.
// When the receiver stalls, the response holds and the back end waits;
// the queue fills and then req_ready drops.
module two_bucket_connection_lookup #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int WAYS          = 4
) (
   input  logic clock,
   input  logic reset,
   tbcl_req_if.sink   req,
   tbcl_rsp_if.source rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);
   import tbcl_pkg::*;

   logic [63:0] max_age_ff;
   logic        q_valid, q_pop, busy;
   req_type     q_head;

   // Maximum age register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= '0;
      end else if (csr_valid) begin
         max_age_ff <= csr_data;
      end
   end

   tbcl_front #(.DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
   );

   tbcl_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .WAYS(WAYS)) u_back (
      .clock(clock), .reset(reset), .max_age(max_age_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
      .rsp(rsp), .busy(busy)
   );

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> !q_pop) else $error("config write during request start");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> busy) else $error("busy low with response");
endmodule

>>> test/two_bucket_connection_lookup_tb.sv
module two_bucket_connection_lookup_tb;
   import tbcl_pkg::*;

   localparam int ENTRIES = 1024;
   localparam int NWAYS   = 4;
   localparam int REQ_W   = $bits(req_type);
   localparam logic [31:0] BUCKET_SEL = 32'(ENTRIES - 1) & ~32'(NWAYS - 1);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_data = '0;

   tbcl_req_if req ();
   tbcl_rsp_if rsp ();

   two_bucket_connection_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow copy of the connection table and the age register.
   logic [KEY_W-1:0] shadow_client [ENTRIES];
   logic [KEY_W-1:0] shadow_server [ENTRIES];
   logic [63:0]      shadow_seen [ENTRIES];
   logic [63:0]      shadow_max_age;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      rsp_count = 0;
   int      hit_count = 0;
   int      stale_count = 0;
   bit      hold_off = 1'b0;
   logic [KEY_W-1:0] known_keys[$];

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("Test completed with failures");
      $finish;
   end

   // Compute the response of one request and update the shadow table.
   function automatic rsp_type lookup_predict(req_type r);
      rsp_type          res;
      logic [KEY_W-1:0] key;
      logic [31:0]      alt_hash;
      logic [31:0]      b1;
      logic [31:0]      b2;
      logic [9:0]       e;
      logic [9:0]       pidx;
      bit               done;
      res = '0;
      done = 1'b0;
      key = {r.key_addr, r.key_port, r.key_proto};
      pidx = r.index;
      if (r.kind == KIND_WRITE) begin
         shadow_client[pidx] = key;
         shadow_server[pidx] = {r.peer_addr, r.peer_port, r.peer_proto};
         shadow_seen[pidx] = r.now;
      end else if (r.kind == KIND_DELETE) begin
         shadow_client[pidx][KEY_W-1 -: 64] = '0;
      end else if (r.kind == KIND_LOOKUP) begin
         alt_hash = (r.hash << SHL) + (r.hash >> SHR);
         b1 = r.hash & BUCKET_SEL;
         b2 = alt_hash & BUCKET_SEL;
         for (int i = 0; i < 2 * NWAYS; i++) begin
            if (!done) begin
               e = (i % 2 == 0) ? 10'(b1 + i / 2) : 10'(b2 + i / 2);
               if (shadow_client[e] == key) begin
                  res.found = 1'b1;
                  res.client_side = 1'b1;
                  res.match_index = e;
                  done = 1'b1;
               end else if (shadow_server[e] == key) begin
                  res.found = 1'b1;
                  res.match_index = e;
                  done = 1'b1;
               end else if (shadow_client[e][KEY_W-1 -: 64] == '0) begin
                  if (!res.free_valid) begin
                     res.free_valid = 1'b1;
                     res.free_index = e;
                  end
               end else if (64'(shadow_max_age + shadow_seen[e]) < r.now) begin
                  if (!res.stale_valid) begin
                     res.stale_valid = 1'b1;
                     res.stale_index = e;
                  end
               end
            end
         end
         if (done) begin
            res.free_valid = 1'b0;
            res.free_index = '0;
            res.stale_valid = 1'b0;
            res.stale_index = '0;
         end
      end
      return res;
   endfunction

   // Response side: stalls on its own pattern, checks each beat.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               $error("response beat with nothing expected");
               error_count++;
            end else begin
               rsp_type exp_rsp;
               exp_rsp = pending_rsp.pop_front();
               if (rsp.payload.found) hit_count++;
               if (rsp.payload.stale_valid) stale_count++;
               if (rsp.payload.found !== exp_rsp.found) begin
                  $error("found: expected %0d, got %0d", exp_rsp.found, rsp.payload.found);
                  error_count++;
               end
               if (rsp.payload.client_side !== exp_rsp.client_side) begin
                  $error("client_side: expected %0d, got %0d",
                         exp_rsp.client_side, rsp.payload.client_side);
                  error_count++;
               end
               if (rsp.payload.match_index !== exp_rsp.match_index) begin
                  $error("match_index: expected %0d, got %0d",
                         exp_rsp.match_index, rsp.payload.match_index);
                  error_count++;
               end
               if (rsp.payload.free_valid !== exp_rsp.free_valid) begin
                  $error("free_valid: expected %0d, got %0d",
                         exp_rsp.free_valid, rsp.payload.free_valid);
                  error_count++;
               end
               if (rsp.payload.free_index !== exp_rsp.free_index) begin
                  $error("free_index: expected %0d, got %0d",
                         exp_rsp.free_index, rsp.payload.free_index);
                  error_count++;
               end
               if (rsp.payload.stale_valid !== exp_rsp.stale_valid) begin
                  $error("stale_valid: expected %0d, got %0d",
                         exp_rsp.stale_valid, rsp.payload.stale_valid);
                  error_count++;
               end
               if (rsp.payload.stale_index !== exp_rsp.stale_index) begin
                  $error("stale_index: expected %0d, got %0d",
                         exp_rsp.stale_index, rsp.payload.stale_index);
                  error_count++;
               end
            end
         end
         @(negedge clock);
         if (hold_off) begin
            rsp.ready <= 1'b0;
         end else if (rsp_count % 200 < 60) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Long receiver hold-off, counted in cycles, while requests keep coming.
   initial begin
      wait (rsp_count >= 150);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      @(negedge clock);
      hold_off = 1'b0;
   end

   int burst_left = 0;

   // Offer one request beat, with bursts and gaps, and wait for acceptance.
   // Valid stays high between beats of a burst and drops only for a gap.
   task automatic send_request(req_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!hold_off) gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(lookup_predict(r));
      @(negedge clock);
   endtask

   task automatic write_max_age(logic [63:0] value);
      // Let the queue drain and any trailing work finish first.
      req.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_max_age = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_request(logic [1:0] kind);
      req_type r;
      logic [KEY_W-1:0] k;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom});
      r.kind = kind;
      // Mostly reuse keys already written so lookups hit.
      if (kind == KIND_LOOKUP && known_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
         {r.key_addr, r.key_port, r.key_proto} = k;
      end
      // Small times keep staleness near the threshold.
      if ($urandom_range(0, 3) != 0) r.now = 64'($urandom_range(0, 2000));
      if (kind == KIND_WRITE && $urandom_range(0, 1) == 1) begin
         // Place the entry in bucket one of this request's own hash.
         r.index = 10'((r.hash & BUCKET_SEL) + $urandom_range(0, NWAYS - 1));
      end
      return r;
   endfunction

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type exp_rsp;
   } vector_type;

   initial begin
      vector_type vectors[$];
      vector_type v;
      req_type    r;
      rsp_type    got;
      int         pick;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_client[i] = '0;
         shadow_server[i] = '0;
         shadow_seen[i] = '0;
      end
      shadow_max_age = '0;
      req.valid = 1'b0;
      req.payload = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: zero key after reset hits empty entry by compare.
      v = '{default: '0};
      v.r = '0;
      v.r.kind = KIND_LOOKUP;
      v.typed = 1'b1;
      v.exp_rsp = '0;
      v.exp_rsp.found = 1'b1;
      v.exp_rsp.client_side = 1'b1;
      vectors.push_back(v);
      // All-ones key on empty table: miss, first free is bucket one way 0.
      v.r = '1;
      v.r.kind = KIND_LOOKUP;
      v.r.now = '0;
      v.exp_rsp = '0;
      v.exp_rsp.free_valid = 1'b1;
      v.exp_rsp.free_index = 10'h3fc;
      vectors.push_back(v);
      // Write, delete and unknown kind give all-zero responses.
      v.r = '1;
      v.r.kind = KIND_WRITE;
      v.r.index = 10'h3fc;
      v.exp_rsp = '0;
      vectors.push_back(v);
      v.r.kind = KIND_NONE;
      vectors.push_back(v);
      v.typed = 1'b0;
      v.r = '1;
      v.r.kind = KIND_LOOKUP;
      vectors.push_back(v);
      v.r.peer_addr = '0;
      v.r.key_addr = '1;
      v.r.key_port = '1;
      v.r.key_proto = '1;
      vectors.push_back(v);
      v.r.kind = KIND_DELETE;
      v.r.index = 10'h3fc;
      vectors.push_back(v);
      v.r.kind = KIND_LOOKUP;
      vectors.push_back(v);
      // Server key match and stale detection at extremes of time.
      r = '0;
      r.kind = KIND_WRITE;
      r.index = 10'd5;
      r.key_addr = 64'h1;
      r.peer_addr = 64'h2;
      r.now = 64'd100;
      v.r = r;
      vectors.push_back(v);
      r.kind = KIND_LOOKUP;
      r.hash = 32'd5;
      r.key_addr = 64'h2;
      v.r = r;
      vectors.push_back(v);
      r.key_addr = 64'h9;
      r.now = '1;
      v.r = r;
      vectors.push_back(v);
      r.now = 64'd100;
      v.r = r;
      vectors.push_back(v);
      r.now = 64'd101;
      r.hash = '1;
      v.r = r;
      vectors.push_back(v);

      foreach (vectors[i]) begin
         send_request(vectors[i].r);
         if (vectors[i].typed) begin
            got = pending_rsp[pending_rsp.size() - 1];
            if (got !== vectors[i].exp_rsp) begin
               $error("table row %0d: expected %h, predicted %h", i,
                      vectors[i].exp_rsp, got);
               error_count++;
            end
         end
      end

      // Random phases under several age settings, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_max_age('1);
            1: write_max_age(64'd0);
            2: write_max_age(64'd500);
            3: write_max_age({$urandom, $urandom});
            default: write_max_age(64'd50);
         endcase
         for (int n = 0; n < 290; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) r = make_request(KIND_LOOKUP);
            else if (pick < 85) r = make_request(KIND_WRITE);
            else if (pick < 97) r = make_request(KIND_DELETE);
            else r = make_request(KIND_NONE);
            if (r.kind == KIND_WRITE) begin
               known_keys.push_back({r.key_addr, r.key_port, r.key_proto});
               known_keys.push_back({r.peer_addr, r.peer_port, r.peer_proto});
               if (known_keys.size() > 64) begin
                  void'(known_keys.pop_front());
                  void'(known_keys.pop_front());
               end
            end
            send_request(r);
         end
      end

      req.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (30) @(posedge clock);
      $display("Covered %0d responses (%0d hits, %0d with a stale entry)",
               rsp_count, hit_count, stale_count);
      $display("over five age settings, with one long receiver stall.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
